/* hdl/fkc_pkg.sv */
// Shared types and constants for the FIFO-replacement key cache.
// Used by the slot cell and by the top level; depends on nothing else.
package fkc_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned OUT_IDX_W   = 4;
  localparam int unsigned CNT_BITS    = 32;
  localparam int unsigned KEY_PORT_W  = 64;
  localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

  // Search request as it walks down the row of slot cells.
  typedef struct packed {
    logic live;
    logic found;
  } fkc_tok_t;

endpackage

/* hdl/fkc_slot_cell.sv */
// One slot of the key cache: stored key, valid mark and one stage of the
// search chain. Depends on fkc_pkg for the search request type.
module fkc_slot_cell import fkc_pkg::*; #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned SLOT     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CNT_W-1:0]    active_n_i,
  input  fkc_tok_t            tok_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [IDX_W-1:0]    fidx_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  logic [KEY_BITS-1:0] wr_key_i,
  output fkc_tok_t            tok_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [IDX_W-1:0]    fidx_o
);

  logic [KEY_BITS-1:0] slot_key_q;
  logic                valid_q;
  fkc_tok_t            tok_d, tok_q;
  logic [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]    fidx_d, fidx_q;
  logic                active;
  logic                hit_here;

  // Slots at or above the configured count take no part in the search.
  assign active   = CNT_W'(SLOT) < active_n_i;
  assign hit_here = tok_i.live && !tok_i.found && valid_q && active &&
                    (slot_key_q == key_i);

  always_comb begin
    tok_d.live  = tok_i.live;
    tok_d.found = tok_i.found | hit_here;
    fidx_d      = hit_here ? IDX_W'(SLOT) : fidx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_en_i && (wr_idx_i == IDX_W'(SLOT))) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_i;
    fidx_q <= fidx_d;
    if (wr_en_i && (wr_idx_i == IDX_W'(SLOT))) begin
      slot_key_q <= wr_key_i;
    end
  end

  assign tok_o  = tok_q;
  assign key_o  = key_q;
  assign fidx_o = fidx_q;

endmodule

/* hdl/fifo_replacement_key_cache_unit.sv */
// Fully associative key cache with FIFO replacement, top level.
// A request's search walks through the row of MAX_SLOTS slot cells, one cell a cycle, and its
// result strobe is registered after the last cell.
// A new request is taken only when idle; busy stays high until the result.
// Reset clears valid marks, replacement pointer, counters and sets the slot count to 16.
// Results are shown for one cycle on done_o; the receiver cannot stall. Uses fkc_slot_cell.
module fifo_replacement_key_cache_unit import fkc_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 16,
  parameter int unsigned KEY_BITS  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_PORT_W-1:0] lookup_key_i,
  output logic                  done_o,
  output logic                  hit_o,
  output logic [OUT_IDX_W-1:0]  slot_index_o,
  output logic [CNT_BITS-1:0]   hit_total_o,
  output logic [CNT_BITS-1:0]   miss_total_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]    slots_q;
  logic [CMP_W-1:0]    cfg_ext;
  logic [CMP_W-1:0]    clamp_n;
  logic [CNT_W-1:0]    active_n;
  logic                busy_q;
  logic                accept;
  logic [IDX_W-1:0]    ptr_d, ptr_q;
  logic [IDX_W-1:0]    fill_idx;
  logic [CNT_W-1:0]    fill_inc;
  logic [CNT_BITS-1:0] hit_cnt_q, miss_cnt_q;
  logic                done_q, hit_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                end_live, wr_en;

  fkc_tok_t            tok_c  [MAX_SLOTS+1];
  logic [KEY_BITS-1:0] key_c  [MAX_SLOTS+1];
  logic [IDX_W-1:0]    fidx_c [MAX_SLOTS+1];

  // Slot count: zero acts as one, anything above the row length as the row length.
  assign cfg_ext  = CMP_W'(slots_q);
  assign clamp_n  = (cfg_ext == '0) ? CMP_W'(1) :
                    (cfg_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : cfg_ext;
  assign active_n = CNT_W'(clamp_n);

  assign cfg_ready_o = 1'b1;
  assign busy        = busy_q;
  assign accept      = start && !busy_q;

  assign tok_c[0].live  = accept;
  assign tok_c[0].found = 1'b0;
  assign key_c[0]       = lookup_key_i[KEY_BITS-1:0];
  assign fidx_c[0]      = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    fkc_slot_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .SLOT     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .active_n_i (active_n),
      .tok_i      (tok_c[g]),
      .key_i      (key_c[g]),
      .fidx_i     (fidx_c[g]),
      .wr_en_i    (wr_en),
      .wr_idx_i   (fill_idx),
      .wr_key_i   (key_c[MAX_SLOTS]),
      .tok_o      (tok_c[g+1]),
      .key_o      (key_c[g+1]),
      .fidx_o     (fidx_c[g+1])
    );
  end

  assign end_live = tok_c[MAX_SLOTS].live;
  assign wr_en    = end_live && !tok_c[MAX_SLOTS].found;

  // A pointer left beyond a lowered slot count restarts at slot zero.
  assign fill_idx = (CNT_W'(ptr_q) < active_n) ? ptr_q : '0;
  assign fill_inc = CNT_W'(fill_idx) + CNT_W'(1);
  assign ptr_d    = (fill_inc == active_n) ? '0 : IDX_W'(fill_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q    <= SLOTS_RESET;
      busy_q     <= 1'b0;
      ptr_q      <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slots_q <= cfg_data_i;
      end
      done_q <= end_live;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (end_live) begin
        busy_q <= 1'b0;
      end
      if (end_live) begin
        if (tok_c[MAX_SLOTS].found) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + CNT_BITS'(1);
          end
        end else begin
          ptr_q <= ptr_d;
          if (miss_cnt_q != '1) begin
            miss_cnt_q <= miss_cnt_q + CNT_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_live) begin
      hit_q     <= tok_c[MAX_SLOTS].found;
      out_idx_q <= tok_c[MAX_SLOTS].found ? fidx_c[MAX_SLOTS] : fill_idx;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign slot_index_o = OUT_IDX_W'(out_idx_q);
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after an accepted request");

  a_fill_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CNT_W'(fill_idx) < active_n))
    else $error("fill slot outside the slots in use");

  a_hit_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> ((hit_total_o != $past(hit_total_o)) || (hit_total_o == '1)))
    else $error("hit reported without counting it");

  a_miss_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> ((miss_total_o != $past(miss_total_o)) || (miss_total_o == '1)))
    else $error("miss reported without counting it");

endmodule

/* tb/fifo_replacement_key_cache_unit_tb.sv */
// Self-checking testbench for the FIFO-replacement key cache top level.
// Holds its own lookup predictor in a small scoreboard class; needs fkc_pkg and the RTL only.
`timescale 1ns / 100ps

module fifo_replacement_key_cache_unit_tb;
  import fkc_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned POOL_DEPTH = 32;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [CNT_BITS-1:0]  hit_total;
    logic [CNT_BITS-1:0]  miss_total;
  } lookup_result_t;

  class fifo_cache_predictor;
    logic [KEY_PORT_W-1:0] slot_keys[NUM_SLOTS];
    bit                    slot_valid[NUM_SLOTS];
    int unsigned           replace_ptr;
    logic [CNT_BITS-1:0]   hit_count;
    logic [CNT_BITS-1:0]   miss_count;
    logic [CFG_W-1:0]      slot_count;
    lookup_result_t        expected_results[$];
    int unsigned           mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_keys[i]  = '0;
      end
      replace_ptr = 0;
      hit_count   = '0;
      miss_count  = '0;
      slot_count  = SLOTS_RESET;
      mismatches  = 0;
    endfunction

    function void set_slot_count(logic [CFG_W-1:0] value);
      slot_count = value;
    endfunction

    // Computes the result of one accepted lookup request and updates the cache copy.
    function void note_lookup(logic [KEY_PORT_W-1:0] key);
      int unsigned    active;
      int unsigned    slot;
      bit             found;
      lookup_result_t res;
      active = (slot_count == 0) ? 1 : ((slot_count > NUM_SLOTS) ? NUM_SLOTS : slot_count);
      found = 1'b0;
      slot = 0;
      for (int unsigned i = 0; i < active; i++) begin
        if (!found && slot_valid[i] && slot_keys[i] == key) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (found) begin
        if (hit_count != '1) hit_count = hit_count + 1'b1;
      end else begin
        if (miss_count != '1) miss_count = miss_count + 1'b1;
        // A pointer left above a lowered slot count restarts at slot zero.
        slot = (replace_ptr < active) ? replace_ptr : 0;
        slot_keys[slot] = key;
        slot_valid[slot] = 1'b1;
        replace_ptr = (slot + 1) % active;
      end
      res.hit        = found;
      res.slot_index = slot[OUT_IDX_W-1:0];
      res.hit_total  = hit_count;
      res.miss_total = miss_count;
      expected_results.push_back(res);
    endfunction

    function void report(string what, lookup_result_t exp_r, lookup_result_t act_r);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t %s: expected hit=%0b slot=%0d hits=%0d misses=%0d, got hit=%0b slot=%0d hits=%0d misses=%0d",
                 $realtime, what, exp_r.hit, exp_r.slot_index, exp_r.hit_total,
                 exp_r.miss_total, act_r.hit, act_r.slot_index, act_r.hit_total,
                 act_r.miss_total);
      end
    endfunction

    function void check_lookup(lookup_result_t act_r);
      lookup_result_t exp_r;
      if (expected_results.size() == 0) begin
        report("result without a pending request", '0, act_r);
        return;
      end
      exp_r = expected_results.pop_front();
      if (act_r.hit !== exp_r.hit || act_r.slot_index !== exp_r.slot_index ||
          act_r.hit_total !== exp_r.hit_total || act_r.miss_total !== exp_r.miss_total) begin
        report("lookup result mismatch", exp_r, act_r);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void flag_leftovers();
      if (expected_results.size() != 0) begin
        $display("%t %0d lookup results never arrived", $realtime, expected_results.size());
        mismatches += expected_results.size();
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KEY_PORT_W-1:0] lookup_key_i;
  logic                  done_o;
  logic                  hit_o;
  logic [OUT_IDX_W-1:0]  slot_index_o;
  logic [CNT_BITS-1:0]   hit_total_o;
  logic [CNT_BITS-1:0]   miss_total_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i;

  fifo_cache_predictor   cache_model;
  logic [KEY_PORT_W-1:0] key_pool[POOL_DEPTH];
  bit                    allow_idle;
  int unsigned           quiet_cycles;

  fifo_replacement_key_cache_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .lookup_key_i (lookup_key_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .slot_index_o (slot_index_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      cache_model.check_lookup('{hit_o, slot_index_o, hit_total_o, miss_total_o});
    end
  end

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fifo_replacement_key_cache_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KEY_PORT_W-1:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_lookup(input logic [KEY_PORT_W-1:0] key);
    int unsigned gap;
    gap = (allow_idle && $urandom_range(99) < 31) ? $urandom_range(1, 20) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      lookup_key_i <= random_key();
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    lookup_key_i <= key;
    do @(posedge clk_i); while (!(start && !busy));
    cache_model.note_lookup(key);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (cache_model.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cache_model.set_slot_count(value);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= CFG_W'($urandom());
  endtask

  // Mostly keys from a small pool so that hits and refills both happen often.
  function automatic logic [KEY_PORT_W-1:0] pick_key(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return key_pool[$urandom_range(span - 1)];
    if (roll < 85) return random_key();
    if (roll < 90) return '0;
    if (roll < 95) return '1;
    return key_pool[$urandom_range(span - 1)] ^ (64'd1 << $urandom_range(63));
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_slots[12];
    int unsigned      span;
    cache_model = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    lookup_key_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    quiet_cycles <= 0;
    allow_idle = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: key extremes, hits, refills, and the slot count corner cases.
    send_lookup('0);
    send_lookup('1);
    send_lookup('0);
    send_lookup('1);
    send_lookup({32{2'b10}});
    send_lookup({32{2'b01}});
    // With one slot the pointer sits above the count, so slot zero is refilled and
    // the same key now lives in slot zero and slot three.
    write_slot_count(5'd1);
    send_lookup({32{2'b01}});
    send_lookup({32{2'b01}});
    // A count above the slot total acts as the full total; the lowest match wins.
    write_slot_count(5'd31);
    send_lookup({32{2'b01}});
    send_lookup('0);
    send_lookup({32{2'b01}});
    send_lookup('1);
    // A count of zero acts as one slot.
    write_slot_count(5'd0);
    send_lookup('0);
    send_lookup(64'h0000_0000_0000_0001);
    send_lookup(64'h8000_0000_0000_0000);
    write_slot_count(5'd16);
    send_lookup(64'h8000_0000_0000_0000);
    send_lookup({32{2'b10}});

    phase_slots = '{5'd16, 5'd2, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd15,
                    5'd3, 5'd5, 5'd12, 5'd16};
    foreach (key_pool[i]) key_pool[i] = random_key();
    for (int ph = 0; ph < 12; ph++) begin
      logic [CFG_W-1:0] slots_val;
      slots_val = (ph >= 8 && ph < 11) ? CFG_W'($urandom()) : phase_slots[ph];
      write_slot_count(slots_val);
      // Keep about half of the old keys so slots left over from earlier counts can hit.
      foreach (key_pool[i]) if ($urandom_range(1)) key_pool[i] = random_key();
      span = $urandom_range(1, POOL_DEPTH);
      allow_idle = (ph != 3);
      for (int n = 0; n < 130; n++) begin
        send_lookup(pick_key(span));
      end
    end
    allow_idle = 1'b1;

    wait_for_results();
    repeat (NUM_SLOTS + 4) @(posedge clk_i);
    cache_model.flag_leftovers();
    if (cache_model.mismatches == 0) begin
      $display("fifo_replacement_key_cache_unit verification clean");
    end else begin
      $display("fifo_replacement_key_cache_unit verification failed");
    end
    $finish;
  end

endmodule
